// ----- hw/rtl/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg
// Types, constants and helpers shared by the skinning block.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int MAT_WORDS   = 12;
	localparam int WEIGHT_FRAC = 16;

	localparam logic       REQ_WRITE  = 1'b0;
	localparam logic       REQ_INFL   = 1'b1;
	localparam logic [1:0] SEL_POSE   = 2'd0;
	localparam logic [1:0] SEL_BIND   = 2'd1;
	localparam logic [1:0] SEL_W2L    = 2'd2;
	localparam logic [1:0] ROW_TRANS  = 2'd3;  // translation row, no multiply

	typedef struct packed {
		logic               req_type;
		logic [1:0]         matrix_select;
		logic [5:0]         joint_index;
		logic [3:0]         matrix_word;
		logic signed [31:0] word_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [16:0]        weight;
		logic               last_influence;
	} item_t;

	typedef struct packed {
		logic signed [31:0] skinned_x;
		logic signed [31:0] skinned_y;
		logic signed [31:0] skinned_z;
		logic               clipped;
	} result_t;

	// one operation for the shared multiplier
	typedef struct packed {
		logic       vld;
		logic       wgt;   // weight scaling, else affine term
		logic [1:0] col;
		logic [1:0] row;
	} mac_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BIND,
		ST_POSE,
		ST_WEIGHT,
		ST_NORM,
		ST_W2L,
		ST_DONE
	} state_t;

	// {clip, value}: signed 64 to 32 saturation
	function automatic logic [32:0] sat32(input logic signed [63:0] x);
		logic [32:0] r;
		if (x > 64'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (x < -64'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, x[31:0]};
		end
		return r;
	endfunction

	// {clip, value}: signed 64-bit saturating add
	function automatic logic [64:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		logic [64:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			r = s[64] ? {1'b1, 1'b1, 63'd0} : {1'b1, 1'b0, {63{1'b1}}};
		end else begin
			r = {1'b0, s[63:0]};
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/linear_blend_skinning.sv -----
// ----------------------------------------------------------------------------
// linear_blend_skinning
// Linear blend skinning, Q16.16 points, one shared multiplier under a sequencer.
// One transaction at a time (item_stall outside the idle state), set by the single
// multiplier and the one read port of each joint store (12 words per matrix).
// Reset: accumulators and clip flag clear, world-to-local loads identity;
// joint stores hold nothing until written, no clearing pass.
// ----------------------------------------------------------------------------
module linear_blend_skinning #(
	parameter int MAX_JOINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  lbs_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output lbs_pkg::result_t result
);
	import lbs_pkg::*;

	localparam int DEPTH = MAX_JOINTS * MAT_WORDS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// sequencer
	state_t     state_q, state_d;
	logic [3:0] cnt_q;
	logic       item_acc;
	logic       load_res;

	// captured influence and working vectors
	item_t              in_q;
	logic signed [31:0] vec_q [3];   // operand point of the current pass
	logic signed [31:0] res_q [3];   // result point of the current pass
	logic signed [63:0] sum_q;       // running column sum
	logic signed [63:0] acc_q [3];
	logic               clip_q;
	logic signed [31:0] w2l_q [MAT_WORDS];
	logic signed [31:0] w2l_rd_s1;

	// issue side
	logic       affine;
	mac_op_t    op_issue, op_s1, op_s2;
	logic [1:0] row_i;
	logic [3:0] word_i;
	logic [1:0] a_idx;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_s2;
	logic signed [31:0] bind_rd, pose_rd;

	logic          w_in_rng;
	logic [AW-1:0] waddr, raddr;
	logic          bind_we, pose_we, w2l_we;

	// accumulate side
	logic signed [63:0] term, sum_new;
	logic [32:0]        col_sat;
	logic [64:0]        acc_sum;
	logic [32:0]        nrm [3];

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign load_res   = (state_q == ST_DONE) && (!result_valid || !result_stall);

	// matrix write decode
	assign w_in_rng = int'(item.joint_index) < MAX_JOINTS;
	assign waddr    = AW'(int'(item.joint_index) * MAT_WORDS + int'(item.matrix_word));
	assign bind_we  = item_acc && item.req_type == REQ_WRITE && item.matrix_word < 4'd12
		&& item.matrix_select == SEL_BIND && w_in_rng;
	assign pose_we  = item_acc && item.req_type == REQ_WRITE && item.matrix_word < 4'd12
		&& item.matrix_select == SEL_POSE && w_in_rng;
	assign w2l_we   = item_acc && item.req_type == REQ_WRITE && item.matrix_word < 4'd12
		&& item.matrix_select == SEL_W2L;

	// Affine pass order: per column, translation word first, then rows 0..2.
	assign affine = (state_q == ST_BIND) || (state_q == ST_POSE) || (state_q == ST_W2L);
	assign row_i  = (cnt_q[1:0] == 2'd0) ? ROW_TRANS : cnt_q[1:0] - 2'd1;
	assign word_i = 4'(row_i) * 4'd3 + 4'(cnt_q[3:2]);
	assign raddr  = AW'(int'(in_q.joint_index) * MAT_WORDS + int'(word_i));

	always_comb begin
		op_issue = '0;
		if (affine && cnt_q < 4'd12) begin
			op_issue.vld = 1'b1;
			op_issue.col = cnt_q[3:2];
			op_issue.row = row_i;
		end else if (state_q == ST_WEIGHT && cnt_q < 4'd3) begin
			op_issue.vld = 1'b1;
			op_issue.wgt = 1'b1;
			op_issue.col = cnt_q[1:0];
		end
	end

	lbs_joint_mem #(.DEPTH(DEPTH), .AW(AW)) u_bind (
		.clk  (clk),
		.we   (bind_we),
		.waddr(waddr),
		.wdata(item.word_value),
		.raddr(raddr),
		.rdata(bind_rd)
	);

	lbs_joint_mem #(.DEPTH(DEPTH), .AW(AW)) u_pose (
		.clk  (clk),
		.we   (pose_we),
		.waddr(waddr),
		.wdata(item.word_value),
		.raddr(raddr),
		.rdata(pose_rd)
	);

	// operand select for the shared multiplier
	assign a_idx = op_s1.wgt ? op_s1.col : op_s1.row;
	always_comb begin
		mul_a = (a_idx == ROW_TRANS) ? vec_q[0] : vec_q[a_idx];
		case (state_q)
			ST_BIND:   mul_b = bind_rd;
			ST_POSE:   mul_b = pose_rd;
			ST_W2L:    mul_b = w2l_rd_s1;
			ST_WEIGHT: mul_b = $signed({15'd0, in_q.weight});
			default:   mul_b = '0;
		endcase
	end

	lbs_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_s1),
		.a      (mul_a),
		.b      (mul_b),
		.op_s2  (op_s2),
		.prod_s2(prod_s2)
	);

	// column sum: floor shift of each product, saturate after the last row
	assign term    = prod_s2 >>> FRAC_BITS;
	assign sum_new = (op_s2.row == ROW_TRANS) ? prod_s2 : sum_q + term;
	assign col_sat = sat32(sum_new);
	assign acc_sum = sat_add64(acc_q[op_s2.col], prod_s2);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nrm[i] = sat32(acc_q[i] >>> WEIGHT_FRAC);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_acc && item.req_type == REQ_INFL) begin
					state_d = (int'(item.joint_index) < MAX_JOINTS) ? ST_BIND : ST_WEIGHT;
				end
			end
			ST_BIND: begin
				if (cnt_q == 4'd14) state_d = ST_POSE;
			end
			ST_POSE: begin
				if (cnt_q == 4'd14) state_d = ST_WEIGHT;
			end
			ST_WEIGHT: begin
				if (cnt_q == 4'd5) state_d = in_q.last_influence ? ST_NORM : ST_IDLE;
			end
			ST_NORM: state_d = ST_W2L;
			ST_W2L: begin
				if (cnt_q == 4'd14) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_res) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control and reset-valued state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			op_s1        <= '0;
			result_valid <= 1'b0;
			clip_q       <= 1'b0;
			for (int i = 0; i < 3; i++) acc_q[i] <= '0;
			for (int i = 0; i < MAT_WORDS; i++) begin
				w2l_q[i] <= (i == 0 || i == 4 || i == 8) ? (32'sd1 <<< FRAC_BITS) : '0;
			end
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 4'd0 : cnt_q + 4'd1;
			op_s1   <= op_issue;
			if (w2l_we) w2l_q[item.matrix_word] <= item.word_value;
			if (op_s2.vld && op_s2.wgt) begin
				acc_q[op_s2.col] <= acc_sum[63:0];
				if (acc_sum[64]) clip_q <= 1'b1;
			end
			if (op_s2.vld && !op_s2.wgt && op_s2.row == 2'd2 && col_sat[32]) begin
				clip_q <= 1'b1;
			end
			if (state_q == ST_NORM && (nrm[0][32] || nrm[1][32] || nrm[2][32])) begin
				clip_q <= 1'b1;
			end
			if (load_res) begin
				result_valid <= 1'b1;
				clip_q       <= 1'b0;
				for (int i = 0; i < 3; i++) acc_q[i] <= '0;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		w2l_rd_s1 <= w2l_q[word_i];
		if (item_acc) begin
			in_q <= item;
			if (int'(item.joint_index) < MAX_JOINTS) begin
				vec_q[0] <= item.pos_x;
				vec_q[1] <= item.pos_y;
				vec_q[2] <= item.pos_z;
			end else begin
				for (int i = 0; i < 3; i++) vec_q[i] <= '0;
			end
		end
		if ((state_q == ST_BIND || state_q == ST_POSE) && cnt_q == 4'd14) begin
			for (int i = 0; i < 3; i++) vec_q[i] <= res_q[i];
		end
		if (state_q == ST_NORM) begin
			for (int i = 0; i < 3; i++) vec_q[i] <= nrm[i][31:0];
		end
		if (op_s2.vld && !op_s2.wgt) begin
			sum_q <= sum_new;
			if (op_s2.row == 2'd2) res_q[op_s2.col] <= col_sat[31:0];
		end
		if (load_res) begin
			result.skinned_x <= res_q[0];
			result.skinned_y <= res_q[1];
			result.skinned_z <= res_q[2];
			result.clipped   <= clip_q;
		end
	end

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	a_mac_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		op_s2.vld |-> (state_q == ST_BIND || state_q == ST_POSE
			|| state_q == ST_W2L || state_q == ST_WEIGHT))
		else $error("multiplier busy outside a pass");

	a_clear_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> (acc_q[0] == 0 && acc_q[1] == 0 && acc_q[2] == 0 && !clip_q))
		else $error("accumulator not cleared after result");

endmodule

// ----- hw/rtl/lbs_joint_mem.sv -----
// ----------------------------------------------------------------------------
// lbs_joint_mem
// Per-joint matrix word store, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbs_joint_mem #(
	parameter int DEPTH = 768,
	parameter int AW    = 10
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic signed [31:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic signed [31:0] rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/lbs_mac.sv -----
// ----------------------------------------------------------------------------
// lbs_mac
// Shared 32x32 signed multiplier with registered product.
// ----------------------------------------------------------------------------
module lbs_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  lbs_pkg::mac_op_t   op,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output lbs_pkg::mac_op_t   op_s2,
	output logic signed [63:0] prod_s2
);
	import lbs_pkg::*;

	logic signed [63:0] mul;

	// translation words bypass the multiplier
	assign mul = (!op.wgt && op.row == ROW_TRANS) ? $signed({{32{b[31]}}, b}) : a * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2 <= '0;
		end else begin
			op_s2 <= op;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= mul;
	end

endmodule

// ----- bench/linear_blend_skinning_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_blend_skinning_test
// Checks the skinning block against a behavioral predictor. Matrix writes
// load the stores, influence transactions are chained into vertices, and
// every emitted point is compared field by field, under several idle and
// stall patterns on both channels.
// ----------------------------------------------------------------------------
module linear_blend_skinning_test;
	import lbs_pkg::*;

	localparam int JOINTS = 64;
	localparam int FRAC   = 16;
	localparam longint CYCLE_LIMIT = 400000;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	linear_blend_skinning #(.MAX_JOINTS(JOINTS), .FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// predictor state
	logic signed [31:0] pose_m [JOINTS*MAT_WORDS];
	logic signed [31:0] bind_m [JOINTS*MAT_WORDS];
	logic signed [31:0] w2l_m  [MAT_WORDS];
	bit                 joint_loaded [JOINTS];
	logic signed [63:0] acc [3];
	bit                 clip_flag;

	item_t   pending_items [$];
	result_t expected_points [$];

	int  send_idle_pct;   // percent of cycles the driver holds off
	int  recv_stall_pct;
	int  phase_idle [4];
	int  phase_stall [4];
	bit  failed;
	longint cycles;

	// append a transaction to the driver queue
	function automatic void queue_item(input item_t it);
		pending_items = {pending_items, it};
	endfunction

	// floor shift then exact sum with translation, saturated per column
	function automatic void affine(input logic signed [31:0] p [3],
		input logic signed [31:0] m [MAT_WORDS], output logic signed [31:0] o [3]);
		logic signed [63:0] s;
		logic signed [63:0] prod;
		for (int c = 0; c < 3; c++) begin
			s = 64'(m[9+c]);
			for (int r = 0; r < 3; r++) begin
				prod = 64'(p[r]) * 64'(m[r*3+c]);
				s += prod >>> FRAC;
			end
			if (s > 64'sd2147483647) begin
				o[c] = 32'sh7FFF_FFFF;
				clip_flag = 1;
			end else if (s < -64'sd2147483648) begin
				o[c] = 32'sh8000_0000;
				clip_flag = 1;
			end else begin
				o[c] = s[31:0];
			end
		end
	endfunction

	function automatic logic signed [63:0] acc_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
			clip_flag = 1;
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		if (s < -65'sh0_8000_0000_0000_0000) begin
			clip_flag = 1;
			return 64'sh8000_0000_0000_0000;
		end
		return s[63:0];
	endfunction

	function automatic void predict_skin(input item_t it);
		logic signed [31:0] p [3], t [3], u [3], s [3], o [3];
		logic signed [31:0] mb [MAT_WORDS], mp [MAT_WORDS];
		logic signed [63:0] sh;
		result_t r;
		int base;
		if (it.req_type == REQ_WRITE) begin
			if (it.matrix_word >= MAT_WORDS) return;
			if (it.matrix_select == SEL_W2L) w2l_m[it.matrix_word] = it.word_value;
			else if (it.matrix_select == SEL_POSE)
				pose_m[it.joint_index*MAT_WORDS + it.matrix_word] = it.word_value;
			else if (it.matrix_select == SEL_BIND)
				bind_m[it.joint_index*MAT_WORDS + it.matrix_word] = it.word_value;
			return;
		end
		p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
		base = it.joint_index * MAT_WORDS;
		for (int k = 0; k < MAT_WORDS; k++) begin
			mb[k] = bind_m[base+k];
			mp[k] = pose_m[base+k];
		end
		affine(p, mb, t);
		affine(t, mp, u);
		for (int c = 0; c < 3; c++)
			acc[c] = acc_add(acc[c], 64'(u[c]) * $signed({47'd0, it.weight}));
		if (!it.last_influence) return;
		for (int c = 0; c < 3; c++) begin
			sh = acc[c] >>> WEIGHT_FRAC;
			if (sh > 64'sd2147483647) begin
				s[c] = 32'sh7FFF_FFFF; clip_flag = 1;
			end else if (sh < -64'sd2147483648) begin
				s[c] = 32'sh8000_0000; clip_flag = 1;
			end else begin
				s[c] = sh[31:0];
			end
		end
		affine(s, w2l_m, o);
		r.skinned_x = o[0]; r.skinned_y = o[1]; r.skinned_z = o[2];
		r.clipped = clip_flag;
		expected_points = {expected_points, r};
		for (int c = 0; c < 3; c++) acc[c] = '0;
		clip_flag = 0;
	endfunction

	// driver: predicts at acceptance, then presents the next queued transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall) predict_skin(item);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted point with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_points.size() == 0) begin
					$display("%0t unexpected result %h", $time, result);
					failed = 1;
				end else begin
					result_t e;
					e = expected_points.pop_front();
					if (e.skinned_x !== result.skinned_x)
						$display("%0t skinned_x exp %h got %h", $time, e.skinned_x,
							result.skinned_x);
					if (e.skinned_y !== result.skinned_y)
						$display("%0t skinned_y exp %h got %h", $time, e.skinned_y,
							result.skinned_y);
					if (e.skinned_z !== result.skinned_z)
						$display("%0t skinned_z exp %h got %h", $time, e.skinned_z,
							result.skinned_z);
					if (e.clipped !== result.clipped)
						$display("%0t clipped exp %b got %b", $time, e.clipped,
							result.clipped);
					if (e !== result) failed = 1;
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $signed($urandom);
			default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
		endcase
	endfunction

	function automatic item_t mk_write(input logic [1:0] sel, input logic [5:0] j,
		input logic [3:0] w, input logic signed [31:0] v);
		item_t it;
		it = '0;
		it.req_type = REQ_WRITE;
		it.matrix_select = sel;
		it.joint_index = j;
		it.matrix_word = w;
		it.word_value = v;
		// junk in the influence fields, ignored on writes
		it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
		it.weight = 17'($urandom); it.last_influence = 1'($urandom);
		return it;
	endfunction

	function automatic item_t mk_infl(input logic [5:0] j, input logic [16:0] wt,
		input bit last);
		item_t it;
		it.req_type = REQ_INFL;
		it.matrix_select = 2'($urandom);
		it.joint_index = j;
		it.matrix_word = 4'($urandom);
		it.word_value = $urandom;
		it.pos_x = rand_q(); it.pos_y = rand_q(); it.pos_z = rand_q();
		it.weight = wt;
		it.last_influence = last;
		return it;
	endfunction

	// load a full matrix: near identity with noise, or fully random
	task automatic load_matrix(input logic [1:0] sel, input logic [5:0] j,
		input bit wild);
		logic signed [31:0] v;
		for (int w = 0; w < MAT_WORDS; w++) begin
			if (wild) v = rand_q();
			else if (w == 0 || w == 4 || w == 8) v = 32'sh0001_0000 + ($urandom_range(8191) - 4096);
			else v = $signed($urandom_range(65535)) - 32'sd32768;
			queue_item(mk_write(sel, j, w[3:0], v));
		end
		if (sel != SEL_W2L) joint_loaded[j] = 1;
	endtask

	// checked between clock edges so every update of the edge has landed
	task automatic wait_drained();
		while (pending_items.size() > 0 || item_valid || expected_points.size() > 0)
			@(negedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic random_vertices(input int n_items);
		int sent;
		int j;
		int nj;
		sent = 0;
		while (sent < n_items) begin
			nj = $urandom_range(4, 1);
			for (int k = 0; k < nj; k++) begin
				do j = $urandom_range(JOINTS-1); while (!joint_loaded[j]);
				case ($urandom_range(9))
					0: queue_item(mk_infl(6'(j), 17'h1FFFF, k == nj-1));
					1: queue_item(mk_infl(6'(j), 17'd0, k == nj-1));
					default: queue_item(mk_infl(6'(j), 17'($urandom_range(65536)),
						k == nj-1));
				endcase
				sent++;
			end
			// occasional matrix rewrite or bad write as noise
			if ($urandom_range(9) == 0) begin
				queue_item(mk_write(2'($urandom), 6'($urandom), 4'($urandom), $urandom));
				if (pending_items[$].matrix_select != 2'd3 &&
					pending_items[$].matrix_word < MAT_WORDS &&
					pending_items[$].matrix_select != SEL_W2L)
					joint_loaded[pending_items[$].joint_index] = joint_loaded[pending_items[$].joint_index];
			end
		end
	endtask

	initial begin
		phase_idle[0] = 0;  phase_idle[1] = 87;  phase_idle[2] = 0;   phase_idle[3] = 25;
		phase_stall[0] = 0; phase_stall[1] = 0;  phase_stall[2] = 87; phase_stall[3] = 25;
		arst_n = 1'b0;
		failed = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < JOINTS*MAT_WORDS; i++) begin
			pose_m[i] = '0;
			bind_m[i] = '0;
		end
		for (int i = 0; i < MAT_WORDS; i++) w2l_m[i] = '0;
		w2l_m[0] = 32'sh0001_0000; w2l_m[4] = 32'sh0001_0000; w2l_m[8] = 32'sh0001_0000;
		for (int i = 0; i < JOINTS; i++) joint_loaded[i] = 0;
		for (int c = 0; c < 3; c++) acc[c] = '0;
		clip_flag = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extreme joints, identity world-to-local, bad writes ignored
		load_matrix(SEL_BIND, 6'd0, 0);
		load_matrix(SEL_POSE, 6'd0, 0);
		load_matrix(SEL_BIND, 6'd63, 1);
		load_matrix(SEL_POSE, 6'd63, 1);
		queue_item(mk_write(2'd3, 6'd0, 4'd0, 32'sh7FFF_FFFF));
		queue_item(mk_write(SEL_POSE, 6'd0, 4'd12, 32'sh8000_0000));
		queue_item(mk_write(SEL_W2L, 6'd5, 4'd15, 32'sh1234_5678));
		queue_item(mk_infl(6'd0, 17'd65536, 1));
		queue_item(mk_infl(6'd63, 17'd0, 0));
		queue_item(mk_infl(6'd63, 17'h1FFFF, 1));
		queue_item(mk_infl(6'd0, 17'd32768, 0));
		queue_item(mk_infl(6'd63, 17'd32768, 0));
		queue_item(mk_infl(6'd0, 17'h1FFFF, 1));
		wait_drained();

		// more joints, sane and wild, and a new world-to-local
		for (int j = 1; j < 8; j++) begin
			load_matrix(SEL_BIND, 6'(j), j > 5);
			load_matrix(SEL_POSE, 6'(j), j > 5);
		end
		load_matrix(SEL_W2L, 6'($urandom), 0);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_idle[ph];
			recv_stall_pct = phase_stall[ph];
			random_vertices(ph == 1 || ph == 2 ? 50 : 60);
			if (ph == 2) load_matrix(SEL_W2L, 6'd0, 1);
			wait_drained();
		end

		if (!failed) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_joint_mem.sv
hw/rtl/lbs_mac.sv
hw/rtl/linear_blend_skinning.sv
bench/linear_blend_skinning_test.sv
